/* rtl/rrt_pkg.sv */
// Shared types and constants for the range ring tracker.
// Holds the opcode and sequencer state encodings and the result struct.
// No dependencies.
package rrt_pkg;

    typedef enum logic [1:0] {
        OP_INCLUDE = 2'd0,
        OP_EXCLUDE = 2'd1,
        OP_QUERY   = 2'd2,
        OP_NOP     = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INC_HEAD,
        ST_INC_NEXT,
        ST_SWEEP,
        ST_DONE
    } state_t;

    // Packed so that accepted sits in bit 0.
    typedef struct packed {
        logic bad_request;
        logic found;
        logic accepted;
    } res_t;

    localparam int RES_BITS = 3;
    localparam int M_DATA_W = 8;

endpackage

/* rtl/range_ring_tracker_core.sv */
// Top level of the range ring tracker: stream ports, configuration register
// and output register around rrt_seq and rrt_ring_mem. Uses rrt_pkg.
//
// Usage:
//   s_ channel: one beat per operation, opcode on tuser, value_a and value_b.
//   m_ channel: one beat per operation carrying accepted, found, bad_request.
//   cfg channel: writes min_history; always ready, write it only when idle.
// Sequence, N = NUM_RANGES:
//   include reads the head entry and settles on it, or else reads the next
//   slot; exclude and query sweep all N entries of the ring store, which
//   reads one entry per cycle on its single read port, and exclude writes
//   back on the write port; a no-operation beat goes straight to done.
//   The next beat is taken in the cycle after the result has moved to the
//   output register, so a new operation never starts before the last is done.
// Reset: aresetn clears the sequencer, head slot and min_history and starts
//   a clearing pass over all N entries of the store; s_tready stays low during it.
// Stall: a result waits in the output register while m_tready is low; the
//   next beat may be taken and worked on, and its result is held in the
//   sequencer until the output register frees.
module range_ring_tracker_core import rrt_pkg::*; #(
    parameter int NUM_RANGES = 16,
    parameter int TIME_BITS  = 48,
    localparam int S_DATA_W  = ((2 * TIME_BITS + 7) / 8) * 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // value_a [TIME_BITS-1:0], value_b above it, zero fill to whole bytes
    input  logic [S_DATA_W-1:0]       s_tdata,
    // opcode [1:0]
    input  logic [1:0]                s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // accepted [0], found [1], bad_request [2], zero fill [7:3]
    output logic [M_DATA_W-1:0]       m_tdata,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [TIME_BITS-1:0]      cfg_data
);

    localparam int AW       = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;
    localparam int DW       = 2 * TIME_BITS;

    logic [TIME_BITS-1:0] min_history_reg;
    logic                 m_valid_reg;
    res_t                 m_res_reg;

    opcode_t              in_op;
    logic [TIME_BITS-1:0] in_a;
    logic [TIME_BITS-1:0] in_b;
    logic                 out_free;
    logic                 res_valid;
    res_t                 res;

    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic [DW-1:0]        mem_rdata;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [DW-1:0]        mem_wdata;

    assign in_op = opcode_t'(s_tuser);
    assign in_a  = s_tdata[0 +: TIME_BITS];
    assign in_b  = s_tdata[TIME_BITS +: TIME_BITS];

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_history_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                min_history_reg <= cfg_data;
            end
            if (res_valid) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - RES_BITS){1'b0}}, m_res_reg};

    rrt_seq #(
        .NUM_RANGES (NUM_RANGES),
        .TIME_BITS  (TIME_BITS),
        .AW         (AW)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_op       (in_op),
        .in_a        (in_a),
        .in_b        (in_b),
        .min_history (min_history_reg),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res         (res)
    );

    rrt_ring_mem #(
        .DEPTH (NUM_RANGES),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

/* rtl/rrt_ring_mem.sv */
// Ring entry store: one write port and one read port, read data registered.
// Each word holds {end, start} of one range. Depends on nothing.
module rrt_ring_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 96
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/rrt_seq.sv */
// Sequencer of the range ring tracker: runs include, exclude and query
// against the ring store, reading entries and writing changed ones back. Uses rrt_pkg.
module rrt_seq import rrt_pkg::*; #(
    parameter int NUM_RANGES = 16,
    parameter int TIME_BITS  = 48,
    parameter int AW         = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  opcode_t                in_op,
    input  logic [TIME_BITS-1:0]   in_a,
    input  logic [TIME_BITS-1:0]   in_b,
    input  logic [TIME_BITS-1:0]   min_history,
    output logic                   mem_re,
    output logic [AW-1:0]          mem_raddr,
    input  logic [2*TIME_BITS-1:0] mem_rdata,
    output logic                   mem_we,
    output logic [AW-1:0]          mem_waddr,
    output logic [2*TIME_BITS-1:0] mem_wdata,
    input  logic                   out_free,
    output logic                   res_valid,
    output res_t                   res
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_RANGES - 1);

    state_t                 state_reg, state_next;
    logic [AW-1:0]          cnt_reg, cnt_next;
    logic [AW-1:0]          head_reg, head_next;
    opcode_t                op_reg, op_next;
    logic [TIME_BITS-1:0]   a_reg, a_next;
    logic [TIME_BITS-1:0]   b_reg, b_next;
    res_t                   res_reg, res_next;

    logic [TIME_BITS-1:0]   ent_start;
    logic [TIME_BITS-1:0]   ent_end;
    logic [AW-1:0]          next_slot;
    logic [TIME_BITS:0]     aged_end;
    logic                   hit;

    assign ent_start = mem_rdata[TIME_BITS-1:0];
    assign ent_end   = mem_rdata[2*TIME_BITS-1:TIME_BITS];
    assign next_slot = (head_reg == LAST_ADDR) ? '0 : head_reg + 1'b1;
    assign aged_end  = {1'b0, ent_end} + {1'b0, min_history};
    // Overlap of [start,end) with [a,b), torn and unused entries excluded
    assign hit = (ent_end != '0) && (ent_start < ent_end) && (a_reg < b_reg)
               && (a_reg < ent_end) && (ent_start < b_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            head_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            head_reg  <= head_next;
        end
        op_reg  <= op_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        res_reg <= res_next;
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        head_next  = head_reg;
        op_next    = op_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        res_next   = res_reg;
        in_ready   = (state_reg == ST_IDLE);
        mem_re     = 1'b0;
        mem_raddr  = head_reg;
        mem_we     = 1'b0;
        mem_waddr  = cnt_reg;
        mem_wdata  = '0;
        res_valid  = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                if (cnt_reg == LAST_ADDR) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (in_valid) begin
                    op_next  = in_op;
                    a_next   = in_a;
                    b_next   = in_b;
                    res_next = '0;
                    cnt_next = '0;
                    case (in_op) inside
                        OP_INCLUDE: begin
                            mem_re     = 1'b1;
                            mem_raddr  = head_reg;
                            state_next = ST_INC_HEAD;
                        end
                        OP_EXCLUDE, OP_QUERY: begin
                            mem_re     = 1'b1;
                            mem_raddr  = '0;
                            state_next = ST_SWEEP;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_INC_HEAD: begin
                mem_waddr = head_reg;
                if ((a_reg >= b_reg) || (a_reg < ent_end)) begin
                    res_next.bad_request = 1'b1;
                    state_next = ST_DONE;
                end else if (ent_end == '0) begin
                    mem_we    = 1'b1;
                    mem_wdata = {b_reg, a_reg};
                    res_next.accepted = 1'b1;
                    state_next = ST_DONE;
                end else if (ent_end == a_reg) begin
                    // contiguous: extend the head entry
                    mem_we    = 1'b1;
                    mem_wdata = {b_reg, ent_start};
                    res_next.accepted = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = next_slot;
                    state_next = ST_INC_NEXT;
                end
            end
            ST_INC_NEXT: begin
                mem_waddr = next_slot;
                mem_wdata = {b_reg, a_reg};
                if ((ent_end == '0) || (aged_end < {1'b0, b_reg})) begin
                    mem_we    = 1'b1;
                    head_next = next_slot;
                    res_next.accepted = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_SWEEP: begin
                // entry cnt arrives now; exclude writes it back while reading the next
                if (op_reg == OP_EXCLUDE) begin
                    mem_we    = 1'b1;
                    mem_waddr = cnt_reg;
                    if (ent_end <= b_reg) begin
                        mem_wdata = '0;
                    end else if (ent_start < b_reg) begin
                        mem_wdata = {ent_end, b_reg};
                    end else begin
                        mem_wdata = mem_rdata;
                    end
                end else if (hit) begin
                    res_next.found = 1'b1;
                end
                if (cnt_reg == LAST_ADDR) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next  = cnt_reg + 1'b1;
                    mem_re    = 1'b1;
                    mem_raddr = cnt_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

endmodule

/* dv/range_ring_tracker_core_tb.sv */
// Self-checking testbench for range_ring_tracker_core: streams include, exclude, query
// and no-operation beats, predicts every result beat and compares it field by field.
// Depends on rrt_pkg and the RTL of the range ring tracker only.
module range_ring_tracker_core_tb import rrt_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_RANGES = 16;
    localparam int TIME_BITS  = 48;
    localparam int S_DATA_W   = 96;
    localparam int CYCLE_LIMIT = 600000;
    localparam logic [TIME_BITS-1:0] T_MAX = {TIME_BITS{1'b1}};

    // Mirror of the ring store and the result beats it is expected to produce.
    class range_ring_scoreboard;
        logic [TIME_BITS-1:0] rng_lo [NUM_RANGES];
        logic [TIME_BITS-1:0] rng_hi [NUM_RANGES];
        int unsigned          head;
        logic [TIME_BITS-1:0] history;
        res_t                 expected_results [$];
        int unsigned          mismatches;
        int unsigned          n_checked;
        int unsigned          n_stored;
        int unsigned          n_full;
        int unsigned          n_bad;
        int unsigned          n_found;

        function new();
            for (int i = 0; i < NUM_RANGES; i++) begin
                rng_lo[i] = '0;
                rng_hi[i] = '0;
            end
            head       = 0;
            history    = '0;
            mismatches = 0;
            n_checked  = 0;
            n_stored   = 0;
            n_full     = 0;
            n_bad      = 0;
            n_found    = 0;
        endfunction

        function void set_history(logic [TIME_BITS-1:0] value);
            history = value;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function logic [TIME_BITS-1:0] head_end();
            return rng_hi[head];
        endfunction

        // Work out the result of one accepted beat and advance the mirror.
        function void note_beat(opcode_t op, logic [TIME_BITS-1:0] a,
                                logic [TIME_BITS-1:0] b);
            res_t        r;
            int unsigned nx;
            logic [TIME_BITS-1:0] s;
            logic [TIME_BITS-1:0] e;
            r = '0;
            case (op)
                OP_INCLUDE: begin
                    nx = (head + 1) % NUM_RANGES;
                    if (a >= b || a < rng_hi[head]) begin
                        r.bad_request = 1'b1;
                        n_bad++;
                    end else if (rng_hi[head] == '0) begin
                        rng_lo[head] = a;
                        rng_hi[head] = b;
                        r.accepted = 1'b1;
                    end else if (rng_hi[head] == a) begin
                        rng_hi[head] = b;
                        r.accepted = 1'b1;
                    end else if (rng_hi[nx] == '0 ||
                                 ({1'b0, rng_hi[nx]} + {1'b0, history}) < {1'b0, b}) begin
                        rng_lo[nx] = a;
                        rng_hi[nx] = b;
                        head = nx;
                        r.accepted = 1'b1;
                    end else begin
                        n_full++;
                    end
                    if (r.accepted) n_stored++;
                end
                OP_EXCLUDE: begin
                    for (int i = 0; i < NUM_RANGES; i++) begin
                        if (rng_hi[i] <= b) begin
                            rng_hi[i] = '0;
                            rng_lo[i] = '0;
                        end else if (rng_lo[i] < b) begin
                            rng_lo[i] = b;
                        end
                    end
                end
                OP_QUERY: begin
                    for (int i = 0; i < NUM_RANGES; i++) begin
                        s = rng_lo[i];
                        e = rng_hi[i];
                        // skip unused and torn entries
                        if (e != '0 && s < e) begin
                            if (a > s) s = a;
                            if (b < e) e = b;
                            if (s < e) r.found = 1'b1;
                        end
                    end
                    if (r.found) n_found++;
                end
                default: r = '0;
            endcase
            expected_results.push_back(r);
        endfunction

        function void report(string what, logic want, logic got);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result %0d %s mismatch: expected %0b, got %0b",
                         $realtime, n_checked, what, want, got);
        endfunction

        // Compare one result beat against the oldest expectation.
        function void check_beat(logic [M_DATA_W-1:0] data);
            res_t want;
            res_t got;
            got = data[RES_BITS-1:0];
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result beat %0h", $realtime, data);
                return;
            end
            want = expected_results.pop_front();
            if (want.accepted !== got.accepted)
                report("accepted", want.accepted, got.accepted);
            if (want.found !== got.found)
                report("found", want.found, got.found);
            if (want.bad_request !== got.bad_request)
                report("bad_request", want.bad_request, got.bad_request);
            n_checked++;
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [TIME_BITS-1:0]  cfg_data;

    range_ring_scoreboard sb;
    bit                   quiet;
    int unsigned          cycles;
    int unsigned          n_sent;

    range_ring_tracker_core #(
        .NUM_RANGES (NUM_RANGES),
        .TIME_BITS  (TIME_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: stall at random, sample at the rising edge.
    always @(negedge aclk) begin
        m_tready = quiet ? 1'b1 : ($urandom_range(0, 99) >= 33);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_beat(m_tdata);
    end

    function automatic logic [TIME_BITS-1:0] rand_time();
        return TIME_BITS'({$urandom, $urandom});
    endfunction

    function automatic logic [TIME_BITS-1:0] back_off(logic [TIME_BITS-1:0] t, int d);
        return (t > TIME_BITS'(d)) ? t - TIME_BITS'(d) : '0;
    endfunction

    task automatic send_beat(input opcode_t op, input logic [TIME_BITS-1:0] a,
                             input logic [TIME_BITS-1:0] b);
        while (!quiet && $urandom_range(0, 99) < 33) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {b, a};
        s_tuser  = op;
        do @(posedge aclk); while (!s_tready);
        sb.note_beat(op, a, b);
        n_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // Hold until every expected beat has come back, then let a sweep finish.
    task automatic drain();
        while (sb.pending() != 0) @(negedge aclk);
        repeat (NUM_RANGES + 4) @(negedge aclk);
    endtask

    task automatic write_history(input logic [TIME_BITS-1:0] value);
        drain();
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_history(value);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Mostly well-formed traffic that follows the head entry, plus some noise.
    task automatic run_traffic(input int count);
        int                   pick;
        logic [TIME_BITS-1:0] cur;
        logic [TIME_BITS-1:0] a;
        logic [TIME_BITS-1:0] b;
        for (int n = 0; n < count; n++) begin
            cur = sb.head_end();
            if (cur == '0) cur = TIME_BITS'($urandom_range(0, 1 << 20));
            pick = $urandom_range(0, 99);
            if (cur > T_MAX - TIME_BITS'(1 << 20)) begin
                send_beat(OP_EXCLUDE, rand_time(), T_MAX);
            end else if (pick < 60) begin
                a = ($urandom_range(0, 99) < 30) ? cur : cur + TIME_BITS'($urandom_range(1, 64));
                b = a + TIME_BITS'($urandom_range(1, 64));
                if ($urandom_range(0, 19) == 0) a = back_off(cur, $urandom_range(1, 8));
                send_beat(OP_INCLUDE, a, b);
            end else if (pick < 78) begin
                a = back_off(cur, $urandom_range(0, 1500));
                b = ($urandom_range(0, 9) == 0) ? back_off(a, $urandom_range(0, 5))
                                                : a + TIME_BITS'($urandom_range(1, 200));
                send_beat(OP_QUERY, a, b);
            end else if (pick < 88) begin
                send_beat(OP_EXCLUDE, rand_time(), back_off(cur, $urandom_range(0, 1200)));
            end else begin
                send_beat(opcode_t'($urandom_range(0, 3)), rand_time(), rand_time());
            end
        end
    endtask

    initial begin
        sb        = new();
        quiet     = 1'b0;
        cycles    = 0;
        n_sent    = 0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        write_history('0);
        send_beat(OP_QUERY,   '0, T_MAX);
        send_beat(OP_INCLUDE, '0, '0);
        send_beat(OP_INCLUDE, 48'd10, 48'd20);
        send_beat(OP_INCLUDE, 48'd20, 48'd30);
        send_beat(OP_INCLUDE, 48'd25, 48'd40);
        send_beat(OP_INCLUDE, 48'd40, 48'd40);
        send_beat(OP_INCLUDE, 48'd50, 48'd60);
        send_beat(OP_QUERY,   48'd30, 48'd50);
        send_beat(OP_QUERY,   48'd29, 48'd31);
        send_beat(OP_QUERY,   48'd40, 48'd35);
        send_beat(OP_NOP,     T_MAX, T_MAX);
        send_beat(OP_EXCLUDE, T_MAX, 48'd15);
        send_beat(OP_QUERY,   48'd10, 48'd15);
        send_beat(OP_EXCLUDE, '0, 48'd30);
        send_beat(OP_INCLUDE, 48'd60, 48'd70);
        send_beat(OP_INCLUDE, T_MAX - 48'd1, T_MAX);
        send_beat(OP_QUERY,   '0, T_MAX);
        send_beat(OP_EXCLUDE, '0, T_MAX);
        send_beat(OP_QUERY,   '0, T_MAX);
        send_beat(OP_INCLUDE, '0, T_MAX);
        send_beat(OP_EXCLUDE, '0, '0);
        send_beat(OP_NOP,     '0, '0);
        send_beat(OP_EXCLUDE, '0, T_MAX);

        // pause the sender until every result is back
        drain();
        run_traffic(340);

        write_history(T_MAX);
        run_traffic(340);

        write_history(48'd40);
        quiet = 1'b1;
        run_traffic(340);
        quiet = 1'b0;

        write_history(48'd600);
        run_traffic(340);

        write_history(TIME_BITS'($urandom_range(0, 3000)));
        run_traffic(340);

        drain();
        repeat (2 * NUM_RANGES) @(negedge aclk);
        $display("Sent %0d beats over five min_history settings; %0d results checked.",
                 n_sent, sb.n_checked);
        $display("Stored %0d, ring full %0d, bad %0d, query hits %0d, mismatches %0d.",
                 sb.n_stored, sb.n_full, sb.n_bad, sb.n_found, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sim.f */
rtl/rrt_pkg.sv
rtl/rrt_ring_mem.sv
rtl/rrt_seq.sv
rtl/range_ring_tracker_core.sv
dv/range_ring_tracker_core_tb.sv
